// ----- design/uvr_pkg.sv -----
package uvr_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;
    localparam logic [2:0] REPL_LEN = 3'd3;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_INVALID,
        LEAD_NEED1,
        LEAD_NEED2,
        LEAD_NEED3
    } lead_class_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_SEQ,
        TAIL_ERR
    } tail_kind_t;

    // replacements first, then the tail result
    typedef struct packed {
        logic [2:0]      repl;
        tail_kind_t      tail;
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            eos;
    } uvr_cmd_t;

    function automatic lead_class_t lead_class(input logic [7:0] b);
        lead_class_t c;
        priority casez (b)
            8'b0???_????: c = LEAD_ASCII;
            8'b10??_????: c = LEAD_INVALID;
            8'b110?_????: c = LEAD_NEED1;
            8'b1110_????: c = LEAD_NEED2;
            8'b1111_0???: c = LEAD_NEED3;
            default:      c = LEAD_INVALID;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] cont_need(input lead_class_t c);
        logic [1:0] n;
        unique case (c)
            LEAD_NEED2: n = 2'd2;
            LEAD_NEED3: n = 2'd3;
            default:    n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

// ----- design/uvr_front.sv -----
module uvr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              strict_mode,
    input  logic [7:0]        in_byte,
    input  logic              end_of_string,
    input  logic              accept,
    output logic              cmd_wr,
    output uvr_pkg::uvr_cmd_t cmd
);
    import uvr_pkg::*;

    logic [7:0] held_reg [3];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic       sticky_reg;
    logic       sticky_next;

    lead_class_t cls_b;
    logic [1:0]  need;
    logic        is_cont;
    logic        do_lead;
    logic        fault;
    logic        seq_good;
    logic        hold_wr;
    logic [1:0]  hold_idx;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;

    always_comb
    begin
        cls_b   = lead_class(in_byte);
        need    = cont_need(lead_class(held_reg[0]));
        is_cont = (in_byte[7:6] == 2'b10);
        v2 = {held_reg[0][4:0], in_byte[5:0]};
        v3 = {held_reg[0][3:0], held_reg[1][5:0], in_byte[5:0]};
        v4 = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0], in_byte[5:0]};
        unique case (need)
            2'd1:    seq_good = (v2 >= 11'h080);
            2'd2:    seq_good = (v3 >= 16'h0800) && ((v3 & 16'hF800) != 16'hD800);
            default: seq_good = (v4 >= 21'h010000) && (v4 < 21'h110000);
        endcase

        do_lead         = 1'b0;
        fault           = 1'b0;
        hold_wr         = 1'b0;
        hold_idx        = held_count_reg;
        held_count_next = held_count_reg;
        sticky_next     = sticky_reg;
        cmd             = '0;
        cmd.tail        = TAIL_NONE;
        cmd.eos         = end_of_string;

        if (held_count_reg == 2'd0)
        begin
            do_lead = 1'b1;
        end
        else if (is_cont)
        begin
            if (held_count_reg >= need)
            begin
                held_count_next = 2'd0;
                if (seq_good)
                begin
                    cmd.tail     = TAIL_SEQ;
                    cmd.count    = {1'b0, need} + 3'd1;
                    cmd.bytes[0] = held_reg[0];
                    unique case (need)
                        2'd1:
                        begin
                            cmd.bytes[1] = in_byte;
                        end
                        2'd2:
                        begin
                            cmd.bytes[1] = held_reg[1];
                            cmd.bytes[2] = in_byte;
                        end
                        default:
                        begin
                            cmd.bytes[1] = held_reg[1];
                            cmd.bytes[2] = held_reg[2];
                            cmd.bytes[3] = in_byte;
                        end
                    endcase
                end
                else
                begin
                    cmd.repl = {1'b0, need} + 3'd1;
                    fault    = 1'b1;
                end
            end
            else
            begin
                hold_wr         = 1'b1;
                held_count_next = held_count_reg + 2'd1;
                if (end_of_string)
                begin
                    cmd.repl        = {1'b0, held_count_reg} + 3'd1;
                    fault           = 1'b1;
                    held_count_next = 2'd0;
                end
            end
        end
        else
        begin
            cmd.repl        = {1'b0, held_count_reg};
            fault           = 1'b1;
            held_count_next = 2'd0;
            do_lead         = 1'b1;
        end

        if (do_lead)
        begin
            unique case (cls_b)
                LEAD_ASCII:
                begin
                    cmd.tail     = TAIL_SEQ;
                    cmd.count    = 3'd1;
                    cmd.bytes[0] = in_byte;
                end
                LEAD_INVALID:
                begin
                    cmd.repl = cmd.repl + 3'd1;
                    fault    = 1'b1;
                end
                default:
                begin
                    hold_wr         = 1'b1;
                    hold_idx        = 2'd0;
                    held_count_next = 2'd1;
                    if (end_of_string)
                    begin
                        cmd.repl        = cmd.repl + 3'd1;
                        fault           = 1'b1;
                        held_count_next = 2'd0;
                    end
                end
            endcase
        end

        if (sticky_reg || (strict_mode && fault))
        begin
            cmd.repl  = 3'd0;
            cmd.tail  = TAIL_NONE;
            cmd.count = 3'd0;
            cmd.bytes = '0;
            hold_wr   = 1'b0;
            held_count_next = 2'd0;
            sticky_next     = 1'b1;
        end

        if (end_of_string)
        begin
            if (sticky_next)
            begin
                cmd.tail = TAIL_ERR;
            end
            held_count_next = 2'd0;
            sticky_next     = 1'b0;
        end

        cmd_wr = accept && ((cmd.repl != 3'd0) || (cmd.tail != TAIL_NONE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            sticky_reg     <= 1'b0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            sticky_reg     <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_wr)
        begin
            held_reg[hold_idx] <= in_byte;
        end
    end

endmodule

// ----- design/uvr_cmd_fifo.sv -----
module uvr_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  uvr_pkg::uvr_cmd_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output uvr_pkg::uvr_cmd_t rd_data,
    output logic              empty
);
    import uvr_pkg::*;

    uvr_cmd_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/uvr_back.sv -----
module uvr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  uvr_pkg::uvr_cmd_t head,
    input  logic              head_empty,
    output logic              head_pop,
    output logic [7:0]        out_byte0,
    output logic [7:0]        out_byte1,
    output logic [7:0]        out_byte2,
    output logic [7:0]        out_byte3,
    output logic [2:0]        out_count,
    output logic              conv_error,
    output logic              string_done,
    output logic              empty,
    input  logic              pop
);
    import uvr_pkg::*;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [3:0][7:0] bytes_reg;
    logic [2:0]      count_reg;
    logic            err_reg;
    logic            done_reg;
    logic [2:0]      idx_reg;
    logic [2:0]      idx_next;

    logic            adv;
    logic            in_repl;
    logic            last;
    logic [3:0][7:0] bytes_next;
    logic [2:0]      count_next;
    logic            err_next;

    always_comb
    begin
        adv     = !head_empty && (!out_valid_reg || pop);
        in_repl = (idx_reg < head.repl);
        last    = in_repl ? ((idx_reg + 3'd1 == head.repl) && (head.tail == TAIL_NONE)) : 1'b1;

        bytes_next = '0;
        count_next = 3'd0;
        err_next   = 1'b0;
        if (in_repl)
        begin
            bytes_next[0] = REPL_B0;
            bytes_next[1] = REPL_B1;
            bytes_next[2] = REPL_B2;
            count_next    = REPL_LEN;
        end
        else
        begin
            unique case (head.tail)
                TAIL_SEQ:
                begin
                    bytes_next = head.bytes;
                    count_next = head.count;
                end
                TAIL_ERR:
                begin
                    err_next = 1'b1;
                end
                default:
                begin
                    count_next = 3'd0;
                end
            endcase
        end

        head_pop = adv && last;
        if (!adv)
        begin
            idx_next = idx_reg;
        end
        else if (last)
        begin
            idx_next = 3'd0;
        end
        else
        begin
            idx_next = idx_reg + 3'd1;
        end

        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bytes_reg <= bytes_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            done_reg  <= last && head.eos;
        end
    end

    assign out_byte0   = bytes_reg[0];
    assign out_byte1   = bytes_reg[1];
    assign out_byte2   = bytes_reg[2];
    assign out_byte3   = bytes_reg[3];
    assign out_count   = count_reg;
    assign conv_error  = err_reg;
    assign string_done = done_reg;
    assign empty       = !out_valid_reg;

endmodule

// ----- design/utf8_validate_replace_unit.sv -----
// Streaming UTF-8 validator: one byte beat in per cycle while full is low
// (push/full), result beats out through a one-entry output register
// (empty/pop). Each input byte is classified in the same cycle it is taken
// and, unless it is only held as part of a sequence or dropped in strict
// mode, becomes one command in a 4-deep queue; the back end turns a command
// into 1 to 4 result beats, one beat per cycle while pop keeps the output
// register free, and full rises only when the queue fills because result
// beats fall behind. A command is registered in the queue and its first
// result beat then in the output register. strict_mode (address 0) drops all
// output from the first fault of a string on and yields one error beat on
// the end-of-string byte; change it only while the block is drained.
module utf8_validate_replace_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_string,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte0,
    output logic [7:0]  out_byte1,
    output logic [7:0]  out_byte2,
    output logic [7:0]  out_byte3,
    output logic [2:0]  out_count,
    output logic        conv_error,
    output logic        string_done
);
    import uvr_pkg::*;

    localparam logic REG_STRICT_MODE = 1'b0;

    logic     strict_mode_reg;
    logic     cfg_wr;
    logic     accept;
    logic     cmd_wr;
    uvr_cmd_t cmd;
    uvr_cmd_t head;
    logic     head_empty;
    logic     head_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_STRICT_MODE) ? {31'd0, strict_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_mode_reg <= 1'b0;
        end
        else if (cfg_wr && (paddr[2] == REG_STRICT_MODE))
        begin
            strict_mode_reg <= pwdata[0];
        end
    end

    assign accept = push && !full;

    uvr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .strict_mode   (strict_mode_reg),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .accept        (accept),
        .cmd_wr        (cmd_wr),
        .cmd           (cmd)
    );

    uvr_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd),
        .full    (full),
        .rd_en   (head_pop),
        .rd_data (head),
        .empty   (head_empty)
    );

    uvr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_empty  (head_empty),
        .head_pop    (head_pop),
        .out_byte0   (out_byte0),
        .out_byte1   (out_byte1),
        .out_byte2   (out_byte2),
        .out_byte3   (out_byte3),
        .out_count   (out_count),
        .conv_error  (conv_error),
        .string_done (string_done),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
